@@ sv/lbrt_pkg.sv @@
// Shared types, constants and display encoding for the longest bit run tracker.
`timescale 1ns / 1ps

package lbrt_pkg;

    localparam int WORD_W = 32;
    localparam int RUN_W  = 6;
    localparam int CNT_W  = 5;
    localparam int SEG_W  = 8;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [RUN_W-1:0]  run_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SEG_W-1:0]  seg_t;

    localparam cnt_t LAST_BIT = cnt_t'(WORD_W - 1);

    localparam seg_t SEG_CODE [10] = '{
        8'b00111111, 8'b00000110, 8'b01011011, 8'b01001111, 8'b01100110,
        8'b01101101, 8'b01111101, 8'b00000111, 8'b01111111, 8'b01100111
    };

    typedef struct packed {
        logic load;
        logic scan;
        logic emit;
    } lbrt_cmd_t;

    typedef struct packed {
        logic word_zero;
        logic last_bit;
    } lbrt_status_t;

    function automatic logic [2*SEG_W-1:0] seg_pair(input run_t v);
        logic [1:0] tens;
        run_t       units;
        priority if (v >= run_t'(30)) tens = 2'd3;
        else if (v >= run_t'(20))     tens = 2'd2;
        else if (v >= run_t'(10))     tens = 2'd1;
        else                          tens = 2'd0;
        units = v - run_t'(tens) * run_t'(10);
        return {SEG_CODE[{2'b00, tens}], SEG_CODE[units[3:0]]};
    endfunction

endpackage

@@ sv/lbrt_dp.sv @@
// Datapath: bit-serial run counters, running maxima and result registers.
`timescale 1ns / 1ps

module lbrt_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lbrt_pkg::lbrt_cmd_t     cmd,
    output lbrt_pkg::lbrt_status_t  status,
    input  lbrt_pkg::word_t         word,
    input  logic                    restart,
    output lbrt_pkg::run_t          max_ones,
    output lbrt_pkg::run_t          max_zeros,
    output lbrt_pkg::run_t          max_alternating,
    output logic [31:0]             display_low,
    output logic [15:0]             display_high
);
    import lbrt_pkg::*;

    word_t shift_reg, shift_next;
    logic  prev_bit_reg, prev_bit_next;
    cnt_t  bit_cnt_reg, bit_cnt_next;
    run_t  run_one_reg, run_one_next;
    run_t  run_zero_reg, run_zero_next;
    run_t  run_alt_reg, run_alt_next;
    run_t  best_ones_reg, best_ones_next;
    run_t  best_zeros_reg, best_zeros_next;
    run_t  best_alt_reg, best_alt_next;
    run_t  max_ones_reg, max_zeros_reg, max_alt_reg;
    logic [31:0] disp_low_reg;
    logic [15:0] disp_high_reg;

    logic  cur_bit;
    run_t  one_new, zero_new, alt_new;

    assign status.word_zero = (word == '0);
    assign status.last_bit  = (bit_cnt_reg == LAST_BIT);

    assign cur_bit  = shift_reg[0];
    assign one_new  = cur_bit ? run_one_reg + run_t'(1) : '0;
    assign zero_new = cur_bit ? '0 : run_zero_reg + run_t'(1);
    assign alt_new  = (bit_cnt_reg == '0 || cur_bit == prev_bit_reg)
                      ? run_t'(1) : run_alt_reg + run_t'(1);

    always_comb
    begin
        shift_next      = shift_reg;
        prev_bit_next   = prev_bit_reg;
        bit_cnt_next    = bit_cnt_reg;
        run_one_next    = run_one_reg;
        run_zero_next   = run_zero_reg;
        run_alt_next    = run_alt_reg;
        best_ones_next  = best_ones_reg;
        best_zeros_next = best_zeros_reg;
        best_alt_next   = best_alt_reg;
        if (cmd.load)
        begin
            shift_next    = word;
            prev_bit_next = 1'b0;
            bit_cnt_next  = '0;
            run_one_next  = '0;
            run_zero_next = '0;
            run_alt_next  = '0;
            if (restart)
            begin
                best_ones_next  = '0;
                best_zeros_next = '0;
                best_alt_next   = '0;
            end
        end
        else if (cmd.scan)
        begin
            shift_next    = {1'b0, shift_reg[WORD_W-1:1]};
            prev_bit_next = cur_bit;
            bit_cnt_next  = bit_cnt_reg + cnt_t'(1);
            run_one_next  = one_new;
            run_zero_next = zero_new;
            run_alt_next  = alt_new;
            if (one_new > best_ones_reg)
                best_ones_next = one_new;
            if (zero_new > best_zeros_reg)
                best_zeros_next = zero_new;
            if (alt_new > best_alt_reg)
                best_alt_next = alt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg    <= '0;
            best_ones_reg  <= '0;
            best_zeros_reg <= '0;
            best_alt_reg   <= '0;
        end
        else
        begin
            bit_cnt_reg    <= bit_cnt_next;
            best_ones_reg  <= best_ones_next;
            best_zeros_reg <= best_zeros_next;
            best_alt_reg   <= best_alt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        prev_bit_reg  <= prev_bit_next;
        run_one_reg   <= run_one_next;
        run_zero_reg  <= run_zero_next;
        run_alt_reg   <= run_alt_next;
        if (cmd.emit)
        begin
            max_ones_reg  <= best_ones_reg;
            max_zeros_reg <= best_zeros_reg;
            max_alt_reg   <= best_alt_reg;
            disp_low_reg  <= {seg_pair(best_zeros_reg), seg_pair(best_ones_reg)};
            disp_high_reg <= seg_pair(best_alt_reg);
        end
    end

    assign max_ones        = max_ones_reg;
    assign max_zeros       = max_zeros_reg;
    assign max_alternating = max_alt_reg;
    assign display_low     = disp_low_reg;
    assign display_high    = disp_high_reg;

`ifndef ASSERT_OFF
    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        best_ones_reg <= run_t'(WORD_W) && best_zeros_reg <= run_t'(WORD_W)
        && best_alt_reg <= run_t'(WORD_W))
        else $error("running maximum exceeds word width");

    a_scan_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |=> best_ones_reg >= $past(best_ones_reg)
                     && best_zeros_reg >= $past(best_zeros_reg)
                     && best_alt_reg >= $past(best_alt_reg))
        else $error("running maximum dropped during scan");

    a_emit_copy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> max_ones == $past(best_ones_reg)
                     && max_alternating == $past(best_alt_reg))
        else $error("result register does not match maxima");
`endif

endmodule

@@ sv/lbrt_ctrl.sv @@
// Controller: sequences load, bit scan and result hand-off.
`timescale 1ns / 1ps

module lbrt_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    output logic                    result_valid,
    input  logic                    result_stall,
    output lbrt_pkg::lbrt_cmd_t     cmd,
    input  lbrt_pkg::lbrt_status_t  status
);
    import lbrt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   accept;
    logic   slot_free;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);
    assign slot_free  = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.word_zero ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.last_bit)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.emit)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

`ifndef ASSERT_OFF
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> result_valid)
        else $error("result not presented after emit");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.last_bit) |=> state_reg == ST_DONE)
        else $error("scan did not finish after last bit");

    a_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.word_zero) |=> state_reg == ST_DONE)
        else $error("zero word entered scan");
`endif

endmodule

@@ sv/longest_bit_run_tracker_top.sv @@
// Top level of the longest bit run tracker: controller plus datapath.
//
//   channel | direction | handshake                   | payload
//   item    | in        | item_valid / item_stall     | word, restart
//   result  | out       | result_valid / result_stall | max_ones, max_zeros,
//           |           |                             | max_alternating,
//           |           |                             | display_low, display_high
//
// A nonzero word passes through a load, the bit-serial run scan over every bit
// and a hand-off to the result register. A zero word skips the scan.
// Reset clears the running maxima and the result valid flag.
// A stalled result holds in its register while the next request is scanned.
`timescale 1ns / 1ps

module longest_bit_run_tracker_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  lbrt_pkg::word_t     word,
    input  logic                restart,
    output logic                result_valid,
    input  logic                result_stall,
    output lbrt_pkg::run_t      max_ones,
    output lbrt_pkg::run_t      max_zeros,
    output lbrt_pkg::run_t      max_alternating,
    output logic [31:0]         display_low,
    output logic [15:0]         display_high
);
    import lbrt_pkg::*;

    lbrt_cmd_t    cmd;
    lbrt_status_t status;

    lbrt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    lbrt_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .word            (word),
        .restart         (restart),
        .max_ones        (max_ones),
        .max_zeros       (max_zeros),
        .max_alternating (max_alternating),
        .display_low     (display_low),
        .display_high    (display_high)
    );

endmodule
